// ===== rtl/loss_interval_mean_tracker_assert.svh =====
// Assertion macros for the loss interval mean tracker checker.
// Included by the checker file only; no other dependencies.
`ifndef LOSS_INTERVAL_MEAN_TRACKER_ASSERT_SVH
`define LOSS_INTERVAL_MEAN_TRACKER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LIMT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define LIMT_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== rtl/limt_pkg.sv =====
// Package for the loss interval mean tracker: widths, constants, types.
// No dependencies.
package limt_pkg;
  localparam int unsigned HistDepthDef   = 9;
  localparam int unsigned WeightCountDef = 8;
  localparam int unsigned SeqW = 48;
  localparam int unsigned LenW = 32;
  localparam logic [3:0] CloseGap = 4'd4;
  localparam logic [3:0] ShortGap = 4'd8;

  typedef struct packed {
    logic        kind;
    logic        is_data;
    logic [47:0] seqno;
    logic [3:0]  ccval;
    logic        cause_is_loss;
    logic [47:0] last_seqno;
    logic [15:0] pend_losses;
    logic [31:0] first_length;
  } in_item_t;

  typedef struct packed {
    logic        added;
    logic        losses_taken;
    logic [31:0] mean_interval;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPDATE, ST_WALK, ST_DIV, ST_MEAN, ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input beat
    logic update;    // apply the entry update, decide on a mean
    logic walk_step; // one entry of the weighted sum
    logic div_start; // start a division
    logic mean_set;  // commit the mean
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mean;
    logic walk_last;
    logic div_busy;
    logic walk_div;  // the current walk entry needs its own division
  } sts_t;

  // Weight of the i-th newest entry; zero past the table or the weight count.
  function automatic logic [3:0] weight_of(input logic [4:0] i, input logic [4:0] wc);
    logic [3:0] w;
    case (i)
      5'd0, 5'd1, 5'd2, 5'd3: w = 4'd10;
      5'd4: w = 4'd8;
      5'd5: w = 4'd6;
      5'd6: w = 4'd4;
      5'd7: w = 4'd2;
      default: w = 4'd0;
    endcase
    if (i >= wc) w = 4'd0;
    return w;
  endfunction

  function automatic logic [3:0] cc_dist(input logic [3:0] a, input logic [3:0] b);
    return a - b;
  endfunction
endpackage

// ===== rtl/limt_if.sv =====
// Valid/ready stream interface carrying one payload per beat.
// Depends on nothing; payload type is a parameter.
interface limt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/loss_interval_mean_tracker.sv =====
// Loss interval history with weighted mean: one result beat per input beat.
// An item without a mean update passes through the update state and then
// offers its result beat; a new beat is taken only once that result beat has
// been accepted. With a mean update the result waits for the update, a walk
// step per stored entry, a division of each short entry with more than one
// loss (in the shared bit-serial divider), and the final mean division.
// Depends on limt_pkg, limt_if, limt_ctrl, limt_dp and limt_div.
module loss_interval_mean_tracker #(
  parameter int unsigned HistDepth   = limt_pkg::HistDepthDef,
  parameter int unsigned WeightCount = limt_pkg::WeightCountDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  limt_if.sink   in_if,
  limt_if.source out_if
);
  import limt_pkg::*;
  cmd_t cmd;
  sts_t sts;

  limt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  limt_dp #(.HistDepth(HistDepth), .WeightCount(WeightCount)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_if.data)
  );
endmodule

// ===== rtl/limt_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// No package dependencies.
module limt_div #(
  parameter int unsigned NW = 80,
  parameter int unsigned DW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;

  // One shift-subtract step per cycle while the counter runs.
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[NW-1]};
    if (cnt_q != '0) begin
      quo_d = {quo_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

// ===== rtl/limt_ctrl.sv =====
// Controller state machine for the loss interval mean tracker.
// Depends on limt_pkg; drives commands to limt_dp and reads its status.
module limt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  limt_pkg::sts_t   sts_i,
  output limt_pkg::cmd_t   cmd_o
);
  import limt_pkg::*;
  state_e state_q, state_d;
  logic   div_wait_q, div_wait_d;

  // Next state.
  always_comb begin
    state_d    = state_q;
    div_wait_d = div_wait_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = sts_i.need_mean ? ST_WALK : ST_OUT;
      ST_WALK: begin
        if (div_wait_q) begin
          if (!sts_i.div_busy) begin
            div_wait_d = 1'b0;
            if (sts_i.walk_last) state_d = ST_DIV;
          end
        end else if (sts_i.walk_div) begin
          div_wait_d = 1'b1;
        end else if (sts_i.walk_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV:    state_d = ST_MEAN;
      ST_MEAN:   if (!sts_i.div_busy) state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_WALK: begin
        if (!div_wait_q && sts_i.walk_div) cmd_o.div_start = 1'b1;
        if ((div_wait_q && !sts_i.div_busy) || (!div_wait_q && !sts_i.walk_div))
          cmd_o.walk_step = 1'b1;
      end
      ST_DIV:  cmd_o.div_start = 1'b1;
      ST_MEAN: cmd_o.mean_set = !sts_i.div_busy;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      div_wait_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      div_wait_q <= div_wait_d;
    end
  end
endmodule

// ===== rtl/limt_dp.sv =====
// Datapath: history ring, entry update, weighted sums and the shared divider.
// Depends on limt_pkg and limt_div.
module limt_dp #(
  parameter int unsigned HistDepth   = limt_pkg::HistDepthDef,
  parameter int unsigned WeightCount = limt_pkg::WeightCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  limt_pkg::in_item_t   in_i,
  input  limt_pkg::cmd_t       cmd_i,
  output limt_pkg::sts_t       sts_o,
  output limt_pkg::out_item_t  out_o
);
  import limt_pkg::*;
  localparam int unsigned SW = $clog2(HistDepth);
  localparam int unsigned CW = $clog2(HistDepth + 1);
  localparam int unsigned NW = 40 + 8;   // sum of weighted 32-bit values
  localparam int unsigned DW = 40;
  localparam logic [SW-1:0] LastSlot = SW'(HistDepth - 1);

  // History storage; read combinationally at the head slot and at the walk slot.
  logic [SeqW-1:0] st_seq [HistDepth];
  logic [3:0]      st_cc  [HistDepth];
  logic [LenW-1:0] st_len [HistDepth];
  logic [31:0]     st_los [HistDepth];
  logic            st_cls [HistDepth];
  logic            st_sht [HistDepth];

  logic [CW-1:0] count_q;
  logic [SW-1:0] head_q;
  logic [31:0]   mean_q;
  in_item_t      it_q;
  logic          added_q, taken_q, need_q;

  // Head entry read and the index for the walk.
  logic [SeqW-1:0] h_seq;
  logic [3:0]      h_cc;
  logic [LenW-1:0] h_len;
  logic [31:0]     h_los;
  logic            h_cls;
  logic [4:0]      idx_q;
  logic [SW-1:0]   wslot_q;
  logic [NW-1:0]   t0_q, t1_q;
  logic [7:0]      w_q;
  // CCVal distance from the newest entry, used for the mean choice.
  logic [3:0]      head_cc_q;

  // Head read is combinational on a small register file.
  assign h_seq = st_seq[head_q];
  assign h_cc  = st_cc[head_q];
  assign h_len = st_len[head_q];
  assign h_los = st_los[head_q];
  assign h_cls = st_cls[head_q];

  // Entry update arithmetic.
  logic [SeqW-1:0] evt, dpk, dev, dnl;
  logic signed [SeqW:0] len_pk, len_ev, len_nw;
  logic [3:0]  dcc;
  logic [32:0] lsum;
  function automatic logic [31:0] clamp(input logic signed [SeqW:0] v);
    if (v[SeqW]) return 32'd0;
    if (v[SeqW-1:32] != '0) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction
  assign evt    = it_q.cause_is_loss ? it_q.seqno + 1'b1 : it_q.seqno;
  assign dpk    = it_q.seqno - h_seq;
  assign dev    = evt - h_seq;
  assign dnl    = it_q.last_seqno - evt;
  assign len_pk = $signed({dpk[SeqW-1], dpk}) + 49'sd1;
  assign len_ev = $signed({dev[SeqW-1], dev});
  assign len_nw = $signed({dnl[SeqW-1], dnl}) + 49'sd1;
  assign dcc    = cc_dist(it_q.ccval, h_cc);
  assign lsum   = {1'b0, h_los} + {17'd0, it_q.pend_losses};

  // Update decision for the captured beat.
  logic          upd_pkt, upd_stale, upd_merge, upd_add, need_c;
  logic [SW-1:0] ns;
  assign upd_pkt   = !it_q.kind && count_q != '0 && it_q.is_data &&
                     len_pk > $signed({17'd0, h_len});
  assign upd_stale = it_q.kind && count_q != '0 && len_ev <= 0;
  assign upd_merge = it_q.kind && count_q != '0 && !upd_stale && !(h_cls || dcc > CloseGap);
  assign upd_add   = it_q.kind && !upd_stale && !upd_merge;
  assign need_c    = (upd_pkt && count_q > CW'(1)) || (upd_add && count_q != '0);
  assign ns        = (head_q == LastSlot) ? '0 : head_q + 1'b1;

  // Walk entry read.
  logic [LenW-1:0] w_len;
  logic [31:0]     w_los;
  logic            w_sht, w_div;
  logic [3:0]      wt0, wt1;
  logic [CW-1:0]   k;
  assign w_len = st_len[wslot_q];
  assign w_los = st_los[wslot_q];
  assign w_sht = st_sht[wslot_q];
  assign w_div = w_sht && (w_los > 32'd1);
  assign k     = count_q - 1'b1;
  assign wt0   = weight_of(idx_q, 5'(WeightCount));
  assign wt1   = (idx_q == 5'd0) ? 4'd0 : weight_of(idx_q - 1'b1, 5'(WeightCount));

  // Shared divider.
  logic          div_start, div_busy, div_done_q, walk_phase;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;
  assign walk_phase = !cmd_i.mean_set && (idx_q <= 5'(k)) && need_q;
  always_comb begin
    div_num = '0;
    div_den = '0;
    if (cmd_i.div_start && w_div && !div_done_q && idx_q <= 5'(k)) begin
      div_num = NW'({1'b0, w_len}) + NW'(w_los) - 1'b1;
      div_den = DW'(w_los);
    end else begin
      div_num = (head_cc_q > ShortGap && t0_q > t1_q) ? t0_q : t1_q;
      div_den = DW'(w_q);
    end
  end
  assign div_start = cmd_i.div_start;

  limt_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Value of the current walk entry, after its division when short with more than one loss.
  logic [NW-1:0] v;
  assign v = w_div ? div_quo : NW'(w_len);

  assign sts_o.need_mean = need_c;
  assign sts_o.walk_last = (idx_q == 5'(k));
  assign sts_o.div_busy  = div_busy;
  assign sts_o.walk_div  = w_div && !div_done_q && walk_phase;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      head_q     <= LastSlot;
      mean_q     <= '0;
      div_done_q <= 1'b0;
    end else begin
      if (cmd_i.div_start && sts_o.walk_div) div_done_q <= 1'b1;
      if (cmd_i.walk_step) div_done_q <= 1'b0;
      if (cmd_i.update && upd_add) begin
        head_q <= ns;
        if (count_q < CW'(HistDepth)) count_q <= count_q + 1'b1;
        if (count_q == '0) mean_q <= it_q.first_length;
      end
      if (cmd_i.mean_set) begin
        mean_q <= (div_quo[NW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
      end
    end
  end

  // Item capture, entry update and walk accumulation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q    <= in_i;
      added_q <= 1'b0;
      taken_q <= 1'b0;
      need_q  <= 1'b0;
    end
    if (cmd_i.update) begin
      idx_q     <= '0;
      t0_q      <= '0;
      t1_q      <= '0;
      w_q       <= '0;
      head_cc_q <= upd_add ? 4'd0 : dcc;
      wslot_q   <= upd_add ? ns : head_q;
      need_q    <= need_c;
      // Packet beat: extend the open interval.
      if (upd_pkt) begin
        if (dcc > CloseGap) st_cls[head_q] <= 1'b1;
        if (count_q > CW'(1)) st_len[head_q] <= clamp(len_pk);
      end
      // Event on the open interval: accumulate its losses.
      if (upd_merge) begin
        st_los[head_q] <= lsum[32] ? 32'hFFFF_FFFF : lsum[31:0];
        taken_q <= 1'b1;
      end
      // Event that starts a new interval; the old head is closed.
      if (upd_add) begin
        if (count_q != '0) begin
          st_cls[head_q] <= 1'b1;
          st_len[head_q] <= clamp(len_ev);
          if (dcc <= ShortGap) st_sht[head_q] <= 1'b1;
        end
        st_seq[ns] <= evt;
        st_cc[ns]  <= it_q.ccval;
        st_cls[ns] <= 1'b0;
        st_sht[ns] <= 1'b0;
        st_los[ns] <= {16'd0, it_q.pend_losses};
        st_len[ns] <= (count_q == '0) ? it_q.first_length : clamp(len_nw);
        added_q    <= 1'b1;
        taken_q    <= 1'b1;
      end
    end
    if (cmd_i.walk_step) begin
      if (idx_q < 5'(k)) begin
        t0_q <= t0_q + v * wt0;
        w_q  <= w_q + 8'(wt0);
      end
      if (idx_q != 5'd0) t1_q <= t1_q + v * wt1;
      idx_q   <= idx_q + 1'b1;
      wslot_q <= (wslot_q == '0) ? LastSlot : wslot_q - 1'b1;
    end
  end

  assign out_o.added         = added_q;
  assign out_o.losses_taken  = taken_q;
  assign out_o.mean_interval = mean_q;
endmodule

// ===== rtl/limt_checker.sv =====
// Port-level checker for the loss interval mean tracker, bound to the top.
// Depends on the assertion macro header.
`include "loss_interval_mean_tracker_assert.svh"
module limt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_added,
  input logic out_taken
);
  // A started interval always consumes the pending losses.
  `LIMT_ASSERT_IMP(a_added_taken, clk_i, rst_ni, out_valid && out_added, out_taken, "added without taken")
  // One item in flight: no input is taken while a result waits.
  `LIMT_ASSERT_IMP(a_one_flight, clk_i, rst_ni, out_valid, !in_ready, "input ready while result pending")
  // An accepted beat leaves the input side closed next cycle.
  `LIMT_ASSERT_NXT(a_busy_after, clk_i, rst_ni, in_valid && in_ready, !in_ready, "ready after accept")
  // A stalled result holds.
  `LIMT_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind loss_interval_mean_tracker limt_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_added(out_if.data.added),
  .out_taken(out_if.data.losses_taken)
);

// ===== tb/sv/loss_interval_mean_tracker_test.sv =====
// Testbench for the loss interval mean tracker: random and directed beats.
// A scoreboard class predicts each result beat. Depends on limt_pkg, limt_if
// and the loss_interval_mean_tracker RTL.
`timescale 1ns / 100ps

// Tracks the interval history and weighted mean, and holds the expected beats.
class interval_scoreboard;
  logic [47:0] ent_seq[9];
  logic [3:0]  ent_cc[9];
  logic [31:0] ent_len[9];
  logic [31:0] ent_loss[9];
  bit          ent_closed[9];
  bit          ent_short[9];
  int unsigned n_entries;
  int unsigned newest;
  logic [31:0] mean_now;
  limt_pkg::out_item_t expected_q[$];
  int errors;

  function new();
    n_entries = 0;
    newest = 8;
    mean_now = '0;
    errors = 0;
  endfunction

  // Signed 48-bit distance from a to b.
  function longint seq_dist(logic [47:0] a, logic [47:0] b);
    logic [47:0] d;
    d = b - a;
    if (d[47]) return longint'({16'b0, d}) - (longint'(1) << 48);
    return longint'({16'b0, d});
  endfunction

  function logic [31:0] clamp_len(longint v);
    if (v < 0) return '0;
    if (v > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function int unsigned slot(int unsigned i);
    return (newest + 9 - (i % 9)) % 9;
  endfunction

  function logic [3:0] cc_gap(logic [3:0] a, logic [3:0] b);
    return a - b;
  endfunction

  function logic [63:0] weight(int unsigned i);
    if (i >= 8) return 0;
    case (i)
      4: return 8;
      5: return 6;
      6: return 4;
      7: return 2;
      default: return 10;
    endcase
  endfunction

  // Weighted sums over the newest entries, with and without the open one.
  function void update_mean(logic [3:0] cc);
    logic [63:0] tot0, tot1, wsum, v, l, m;
    int unsigned k, s;
    if (n_entries < 2) return;
    tot0 = 0;
    tot1 = 0;
    wsum = 0;
    k = n_entries - 1;
    for (int unsigned i = 0; i <= k; i++) begin
      s = slot(i);
      v = {32'b0, ent_len[s]};
      if (ent_short[s] && ent_loss[s] != 0) begin
        l = {32'b0, ent_loss[s]};
        v = (v + l - 1) / l;
      end
      if (i < k) begin
        tot0 += v * weight(i);
        wsum += weight(i);
      end
      if (i > 0) tot1 += v * weight(i - 1);
    end
    if (wsum == 0) return;
    if (cc_gap(cc, ent_cc[slot(0)]) > limt_pkg::ShortGap)
      m = ((tot0 > tot1) ? tot0 : tot1) / wsum;
    else
      m = tot1 / wsum;
    mean_now = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
  endfunction

  // Accepted input beat: advance the history and queue the expected beat.
  function void note_input(limt_pkg::in_item_t x);
    limt_pkg::out_item_t r;
    int unsigned s;
    longint len;
    logic [47:0] evt;
    logic [32:0] sum;
    bit go;
    r = '0;
    if (x.kind == 1'b0) begin
      if (n_entries > 0 && x.is_data) begin
        s = slot(0);
        len = seq_dist(ent_seq[s], x.seqno) + 1;
        if (len > longint'(ent_len[s])) begin
          if (cc_gap(x.ccval, ent_cc[s]) > limt_pkg::CloseGap) ent_closed[s] = 1'b1;
          if (n_entries > 1) begin
            ent_len[s] = clamp_len(len);
            update_mean(x.ccval);
          end
        end
      end
    end else begin
      evt = x.cause_is_loss ? x.seqno + 48'd1 : x.seqno;
      go = 1'b1;
      if (n_entries > 0) begin
        s = slot(0);
        len = seq_dist(ent_seq[s], evt);
        if (len <= 0) begin
          go = 1'b0;
        end else begin
          if (cc_gap(x.ccval, ent_cc[s]) > limt_pkg::CloseGap) ent_closed[s] = 1'b1;
          if (!ent_closed[s]) begin
            sum = {1'b0, ent_loss[s]} + {17'b0, x.pend_losses};
            ent_loss[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r.losses_taken = 1'b1;
            go = 1'b0;
          end else begin
            ent_len[s] = clamp_len(len);
            if (cc_gap(x.ccval, ent_cc[s]) <= limt_pkg::ShortGap) ent_short[s] = 1'b1;
          end
        end
      end
      if (go) begin
        newest = (newest + 1) % 9;
        s = newest;
        ent_seq[s] = evt;
        ent_cc[s] = x.ccval;
        ent_closed[s] = 1'b0;
        ent_short[s] = 1'b0;
        ent_loss[s] = {16'b0, x.pend_losses};
        r.losses_taken = 1'b1;
        r.added = 1'b1;
        if (n_entries == 0) begin
          n_entries = 1;
          ent_len[s] = x.first_length;
          mean_now = x.first_length;
        end else begin
          if (n_entries < 9) n_entries++;
          ent_len[s] = clamp_len(seq_dist(evt, x.last_seqno) + 1);
          update_mean(x.ccval);
        end
      end
    end
    r.mean_interval = mean_now;
    expected_q.push_back(r);
  endfunction

  // Accepted result beat: compare with the oldest expectation.
  function void check_result(limt_pkg::out_item_t y);
    limt_pkg::out_item_t e;
    if (expected_q.size() == 0) begin
      if (errors < 10) $display("unexpected result beat %p", y);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (e !== y) begin
      if (errors < 10) $display("mismatch: expected %p, got %p", e, y);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module loss_interval_mean_tracker_test;
  import limt_pkg::*;

  logic clk;
  logic rst_n;
  bit   long_hold;
  interval_scoreboard sb;

  limt_if #(.T(in_item_t))  in_if ();
  limt_if #(.T(out_item_t)) out_if ();

  loss_interval_mean_tracker dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Overall time limit.
  initial begin
    #200_000_000;
    $display("loss_interval_mean_tracker_test NOT OK");
    $finish;
  end

  // Observe accepted beats on both channels.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_input(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Result receiver; a requested long hold stalls it.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (4000) @(posedge clk);
        long_hold = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  function automatic in_item_t make_item(logic k, logic d, logic [47:0] sq, logic [3:0] cc,
                                         logic ls, logic [47:0] last, logic [15:0] nl,
                                         logic [31:0] fl);
    in_item_t x;
    x.kind = k;
    x.is_data = d;
    x.seqno = sq;
    x.ccval = cc;
    x.cause_is_loss = ls;
    x.last_seqno = last;
    x.pend_losses = nl;
    x.first_length = fl;
    return x;
  endfunction

  // Offer one beat after a random gap and wait for its acceptance.
  task automatic send_item(in_item_t x);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= x;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  logic [47:0] cur_seq;
  logic [3:0]  cur_cc;
  in_item_t    item;
  int unsigned r;

  initial begin
    sb = new();
    long_hold = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty history, first interval, stale events, wrap, saturation.
    send_item(make_item(0, 1, 48'd100, 4'd0, 0, '1, 16'hFFFF, '1));
    send_item(make_item(1, 0, '1, 4'd15, 1, 48'd10, 16'd3, 32'hFFFF_FFFF));
    send_item(make_item(0, 0, 48'd20, 4'd15, 0, '0, '0, '0));
    send_item(make_item(0, 1, 48'd30, 4'd15, 1, '0, '0, '0));
    send_item(make_item(1, 0, '1, 4'd0, 0, '0, 16'd1, '0));
    send_item(make_item(1, 0, 48'd5, 4'd0, 0, 48'd9, 16'hFFFF, '0));
    send_item(make_item(1, 0, 48'd6, 4'd1, 1, 48'd12, 16'hFFFF, '0));
    send_item(make_item(0, 1, 48'd40, 4'd5, 0, '0, '0, '0));
    send_item(make_item(1, 0, 48'd41, 4'd5, 0, 48'd60, 16'd2, '0));
    send_item(make_item(0, 1, 48'd70, 4'd7, 0, '0, '0, '0));
    send_item(make_item(1, 0, 48'd75, 4'd14, 1, 48'd90, 16'd4, '0));
    send_item(make_item(0, 1, 48'd95, 4'd3, 0, '0, '0, '0));
    send_item(make_item(1, 0, 48'd96, 4'd10, 0, 48'd200, 16'd7, '0));
    send_item(make_item(0, 1, 48'h8000_0000_0000, 4'd15, 0, '0, '0, '0));
    send_item(make_item(1, 0, 48'h8000_0000_0010, 4'd12, 0, 48'h8000_0001_0000, 16'd1, '0));
    send_item(make_item(1, 0, 48'h8000_0000_0020, 4'd1, 1, '1, 16'hFFFF, '0));
    send_item(make_item(1, 0, 48'h8000_0000_0030, 4'd6, 0, 48'd0, 16'd0, '0));
    send_item(make_item(0, 1, 48'h8000_0000_0040, 4'd6, 0, '1, '1, '1));
    send_item(make_item(1, 0, 48'h8000_0000_0050, 4'd15, 0, 48'h8000_0000_0100, 16'd2, '0));

    // Random: mostly well-formed packet and event streams, some noise.
    cur_seq = rand48();
    cur_cc = 4'($urandom());
    for (int n = 0; n < 1750; n++) begin
      if (n == 300) long_hold = 1;
      if (n == 900) begin
        // Pause the sender until every expected result has come.
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if ($urandom_range(0, 49) == 0) begin
        cur_seq = rand48();
        cur_cc = 4'($urandom());
      end
      r = $urandom_range(0, 99);
      item = make_item(1'($urandom()), 1'($urandom()), rand48(), 4'($urandom()),
                       1'($urandom()), rand48(), 16'($urandom()), $urandom());
      if (r < 55) begin
        cur_seq += 48'($urandom_range(1, 20));
        r = $urandom_range(0, 9);
        if (r < 2) cur_cc += 4'($urandom_range(1, 3));
        else if (r == 2) cur_cc += 4'($urandom_range(5, 12));
        item.kind = 1'b0;
        item.is_data = 1'b1;
        item.seqno = cur_seq;
        item.ccval = cur_cc;
      end else if (r < 62) begin
        item.kind = 1'b0;
        item.is_data = 1'b0;
      end else if (r < 92) begin
        item.kind = 1'b1;
        item.seqno = cur_seq - 48'($urandom_range(0, 5));
        item.ccval = cur_cc;
        item.last_seqno = cur_seq + 48'($urandom_range(0, 10));
        r = $urandom_range(0, 19);
        item.pend_losses = (r == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
        item.first_length = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 1000);
      end
      send_item(item);
    end
    in_if.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("loss_interval_mean_tracker_test OK");
    end else begin
      $display("loss_interval_mean_tracker_test NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/limt_pkg.sv
rtl/limt_if.sv
rtl/limt_div.sv
rtl/limt_ctrl.sv
rtl/limt_dp.sv
rtl/loss_interval_mean_tracker.sv
rtl/limt_checker.sv
tb/sv/loss_interval_mean_tracker_test.sv
